// ===== hw/rtl/paq_pkg.sv =====
// ----------------------------------------------------------------------------
// paq_pkg
// Shared types and constants for the phase alarm qualifier.
// ----------------------------------------------------------------------------
package paq_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    REG_VOLTAGE_MIN    = 3'd0,
    REG_VOLTAGE_MAX    = 3'd1,
    REG_CURRENT_MAX    = 3'd2,
    REG_LOSS_THRESHOLD = 3'd3,
    REG_MIN_DURATION   = 3'd4
  } reg_idx_t;

  localparam logic [15:0] VOLTAGE_MIN_RST    = 16'd10500;
  localparam logic [15:0] VOLTAGE_MAX_RST    = 16'd13500;
  localparam logic [15:0] CURRENT_MAX_RST    = 16'd7000;
  localparam logic [15:0] LOSS_THRESHOLD_RST = 16'd5000;
  localparam logic [31:0] MIN_DURATION_RST   = 32'd5000;

  typedef struct packed {
    logic [15:0] voltage_min;
    logic [15:0] voltage_max;
    logic [15:0] current_max;
    logic [15:0] loss_threshold;
    logic [31:0] min_duration;
  } cfg_t;

  typedef struct packed {
    logic loss;
    logic ihigh;
    logic vhigh;
    logic vlow;
  } flags_t;

  typedef struct packed {
    logic [31:0] volt_stamp;
    logic [31:0] curr_stamp;
    logic [31:0] loss_stamp;
    flags_t      flags;
  } entry_t;

endpackage

// ===== hw/rtl/paq_regs.sv =====
// ----------------------------------------------------------------------------
// paq_regs
// APB-style configuration registers for thresholds and minimum duration.
// ----------------------------------------------------------------------------
module paq_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [paq_pkg::ADDR_W-1:0]    paddr,
  input  logic [paq_pkg::DATA_W-1:0]    pwdata,
  output logic [paq_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output paq_pkg::cfg_t                 cfg
);

  logic             wr_en;
  logic [2:0]       idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.voltage_min    <= paq_pkg::VOLTAGE_MIN_RST;
      cfg.voltage_max    <= paq_pkg::VOLTAGE_MAX_RST;
      cfg.current_max    <= paq_pkg::CURRENT_MAX_RST;
      cfg.loss_threshold <= paq_pkg::LOSS_THRESHOLD_RST;
      cfg.min_duration   <= paq_pkg::MIN_DURATION_RST;
    end else if (wr_en) begin
      case (idx)
        paq_pkg::REG_VOLTAGE_MIN:    cfg.voltage_min    <= pwdata[15:0];
        paq_pkg::REG_VOLTAGE_MAX:    cfg.voltage_max    <= pwdata[15:0];
        paq_pkg::REG_CURRENT_MAX:    cfg.current_max    <= pwdata[15:0];
        paq_pkg::REG_LOSS_THRESHOLD: cfg.loss_threshold <= pwdata[15:0];
        paq_pkg::REG_MIN_DURATION:   cfg.min_duration   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      paq_pkg::REG_VOLTAGE_MIN:    prdata = {16'd0, cfg.voltage_min};
      paq_pkg::REG_VOLTAGE_MAX:    prdata = {16'd0, cfg.voltage_max};
      paq_pkg::REG_CURRENT_MAX:    prdata = {16'd0, cfg.current_max};
      paq_pkg::REG_LOSS_THRESHOLD: prdata = {16'd0, cfg.loss_threshold};
      paq_pkg::REG_MIN_DURATION:   prdata = cfg.min_duration;
      default:                     prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/paq_state_mem.sv =====
// ----------------------------------------------------------------------------
// paq_state_mem
// Per-phase state memory, one write and one registered read port.
// Entries never written read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module paq_state_mem #(
  parameter int unsigned DEPTH  = 3,
  parameter int unsigned ADDR_W = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output paq_pkg::entry_t     rd_data,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  paq_pkg::entry_t     wr_data
);

  paq_pkg::entry_t  mem [DEPTH];
  logic [DEPTH-1:0] vld;
  paq_pkg::entry_t  rd_q;
  logic             rd_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_ok ? rd_q : '0;

endmodule

// ===== hw/rtl/paq_update.sv =====
// ----------------------------------------------------------------------------
// paq_update
// Alarm qualification for one reading against its phase entry.
// ----------------------------------------------------------------------------
module paq_update (
  input  paq_pkg::cfg_t    cfg,
  input  paq_pkg::entry_t  cur,
  input  logic [15:0]      voltage_rms,
  input  logic [15:0]      current_rms,
  input  logic [31:0]      time_ms,
  output paq_pkg::entry_t  upd
);

  logic [31:0] el_loss;
  logic [31:0] el_volt;
  logic [31:0] el_curr;
  logic        held_loss;
  logic        held_volt;
  logic        held_curr;

  assign el_loss   = time_ms - cur.loss_stamp;
  assign el_volt   = time_ms - cur.volt_stamp;
  assign el_curr   = time_ms - cur.curr_stamp;
  assign held_loss = el_loss >= cfg.min_duration;
  assign held_volt = el_volt >= cfg.min_duration;
  assign held_curr = el_curr >= cfg.min_duration;

  always_comb begin
    upd = cur;
    // phase loss first
    if (voltage_rms >= cfg.loss_threshold) begin
      upd.loss_stamp = time_ms;
      upd.flags.loss = 1'b0;
    end else if (held_loss) begin
      upd.flags.loss = 1'b1;
    end

    if (upd.flags.loss) begin
      upd.flags.vlow  = 1'b0;
      upd.flags.vhigh = 1'b0;
      upd.flags.ihigh = 1'b0;
      upd.volt_stamp  = time_ms;
      upd.curr_stamp  = time_ms;
    end else begin
      if (voltage_rms >= cfg.voltage_min && voltage_rms <= cfg.voltage_max) begin
        upd.volt_stamp  = time_ms;
        upd.flags.vlow  = 1'b0;
        upd.flags.vhigh = 1'b0;
      end else if (held_volt) begin
        upd.flags.vlow  = voltage_rms < cfg.voltage_min;
        upd.flags.vhigh = !(voltage_rms < cfg.voltage_min);
      end
      if (current_rms <= cfg.current_max) begin
        upd.curr_stamp  = time_ms;
        upd.flags.ihigh = 1'b0;
      end else if (held_curr) begin
        upd.flags.ihigh = 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/phase_alarm_qualifier_top.sv =====
// ----------------------------------------------------------------------------
// phase_alarm_qualifier_top
// Per-phase over/undervoltage, overcurrent and phase-loss alarm qualifier.
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+---------------------------------
//  in      | sink      | in_valid / in_stall | phase_index, voltage_rms,
//          |           |                     | current_rms, time_ms
//  out     | source    | out_valid/out_stall | phase_out, voltage_low,
//          |           |                     | voltage_high, current_high,
//          |           |                     | phase_lost
//  apb     | slave     | psel/penable/pready | 5 registers at 4*i
//
// One word per cycle sustained unless out_stall holds the result; state memory
// is read at the accepting edge, then update, write-back and result register.
// Same-phase back-to-back words are served by a forwarding register from the
// write-back.
// Synchronous reset clears the per-entry valid bits, so state reads as zero.
// in_stall rises only while the update stage is full and the result is stalled.
// ----------------------------------------------------------------------------
module phase_alarm_qualifier_top #(
  parameter int unsigned PHASE_COUNT = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  phase_index,
  input  logic [15:0]                 voltage_rms,
  input  logic [15:0]                 current_rms,
  input  logic [31:0]                 time_ms,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  phase_out,
  output logic                        voltage_low,
  output logic                        voltage_high,
  output logic                        current_high,
  output logic                        phase_lost,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [paq_pkg::ADDR_W-1:0]  paddr,
  input  logic [paq_pkg::DATA_W-1:0]  pwdata,
  output logic [paq_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned AW = (PHASE_COUNT > 1) ? $clog2(PHASE_COUNT) : 1;

  paq_pkg::cfg_t    cfg;
  paq_pkg::entry_t  rd_data;
  paq_pkg::entry_t  cur;
  paq_pkg::entry_t  upd;
  paq_pkg::entry_t  fwd_data;
  logic             fwd_hit;

  logic             in_fire;
  logic             in_range;
  logic [AW-1:0]    in_addr;

  logic             s1_valid;
  logic             s1_fire;
  logic             s1_in_range;
  logic [1:0]       s1_phase;
  logic [AW-1:0]    s1_addr;
  logic [15:0]      s1_voltage;
  logic [15:0]      s1_current;
  logic [31:0]      s1_time;
  logic             wr_en;

  paq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign s1_fire  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_fire;
  assign in_fire  = in_valid && !in_stall;
  assign in_range = 32'(phase_index) < PHASE_COUNT;
  assign in_addr  = in_range ? AW'(phase_index) : '0;
  assign wr_en    = s1_fire && s1_in_range;

  paq_state_mem #(
    .DEPTH  (PHASE_COUNT),
    .ADDR_W (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_fire),
    .rd_addr (in_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (upd)
  );

  assign cur = fwd_hit ? fwd_data : rd_data;

  paq_update u_update (
    .cfg         (cfg),
    .cur         (cur),
    .voltage_rms (s1_voltage),
    .current_rms (s1_current),
    .time_ms     (s1_time),
    .upd         (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
        fwd_hit  <= wr_en && (s1_addr == in_addr);
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_in_range <= in_range;
      s1_phase    <= phase_index;
      s1_addr     <= in_addr;
      s1_voltage  <= voltage_rms;
      s1_current  <= current_rms;
      s1_time     <= time_ms;
      fwd_data    <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      phase_out    <= s1_phase;
      voltage_low  <= s1_in_range && upd.flags.vlow;
      voltage_high <= s1_in_range && upd.flags.vhigh;
      current_high <= s1_in_range && upd.flags.ihigh;
      phase_lost   <= s1_in_range && upd.flags.loss;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_loss_masks_others: assert property (@(posedge clk) disable iff (rst)
    (out_valid && phase_lost) |-> (!voltage_low && !voltage_high && !current_high))
    else $error("phase loss reported with other alarms");

  a_volt_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(voltage_low && voltage_high))
    else $error("voltage low and high together");

  a_bad_phase_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !(32'(phase_out) < PHASE_COUNT)) |->
      (!voltage_low && !voltage_high && !current_high && !phase_lost))
    else $error("alarms on an absent phase");

endmodule

// ===== verif/tb_phase_alarm_qualifier_top.sv =====
// ----------------------------------------------------------------------------
// tb_phase_alarm_qualifier_top
// Self-checking bench for the phase alarm qualifier. A short run of edge-case
// readings at reset settings, then random fault sequences under several
// register settings, with random gaps on input and random stalls on results.
// Each result word is compared with an in-bench model of the per-phase
// qualifiers; register writes are read back.
// ----------------------------------------------------------------------------
module tb_phase_alarm_qualifier_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PHASES     = 3;
  localparam int unsigned IDLE_LIMIT = 2000;

  typedef struct {
    logic [1:0]  ph;
    logic [15:0] volt;
    logic [15:0] curr;
    logic [31:0] stamp_ms;
  } reading_t;

  typedef struct {
    logic [1:0]       ph;
    paq_pkg::flags_t  flags;
  } report_t;

  logic                       clk          = 1'b0;
  logic                       rst          = 1'b1;
  logic                       in_valid     = 1'b0;
  logic                       in_stall;
  logic [1:0]                 phase_index  = '0;
  logic [15:0]                voltage_rms  = '0;
  logic [15:0]                current_rms  = '0;
  logic [31:0]                time_ms      = '0;
  logic                       out_valid;
  logic                       out_stall    = 1'b0;
  logic [1:0]                 phase_out;
  logic                       voltage_low;
  logic                       voltage_high;
  logic                       current_high;
  logic                       phase_lost;
  logic                       psel         = 1'b0;
  logic                       penable      = 1'b0;
  logic                       pwrite       = 1'b0;
  logic [paq_pkg::ADDR_W-1:0] paddr        = '0;
  logic [paq_pkg::DATA_W-1:0] pwdata       = '0;
  logic [paq_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  phase_alarm_qualifier_top #(.PHASE_COUNT(PHASES)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .phase_index(phase_index), .voltage_rms(voltage_rms),
    .current_rms(current_rms), .time_ms(time_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .phase_out(phase_out), .voltage_low(voltage_low),
    .voltage_high(voltage_high), .current_high(current_high),
    .phase_lost(phase_lost),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // qualifier model state
  paq_pkg::cfg_t   model_cfg = {paq_pkg::VOLTAGE_MIN_RST, paq_pkg::VOLTAGE_MAX_RST,
                                paq_pkg::CURRENT_MAX_RST, paq_pkg::LOSS_THRESHOLD_RST,
                                paq_pkg::MIN_DURATION_RST};
  logic [31:0]     volt_ok  [PHASES] = '{default: '0};
  logic [31:0]     curr_ok  [PHASES] = '{default: '0};
  logic [31:0]     loss_ok  [PHASES] = '{default: '0};
  paq_pkg::flags_t flag_mem [PHASES] = '{default: '0};

  reading_t    readings_todo[$];
  report_t     flags_due[$];
  int unsigned readings_fed   = 0;
  int unsigned readings_taken = 0;
  int unsigned mismatches     = 0;
  int unsigned quiet          = 0;

  bit          in_hit     = 1'b0;
  bit          out_hit    = 1'b0;
  int unsigned in_gap     = 0;
  int unsigned stall_left = 0;
  int unsigned gap_max    = 0;
  int unsigned stall_max  = 0;

  // random sequence shaping
  logic [2:0]  fault_kind   [PHASES] = '{default: '0};
  bit          over_current [PHASES] = '{default: 1'b0};
  logic [31:0] clock_ms = '0;
  int unsigned step_cap = 1000;

  function automatic bit held(input logic [31:0] now, input logic [31:0] since);
    logic [31:0] gap;
    gap = now - since;
    return gap >= model_cfg.min_duration;
  endfunction

  function automatic paq_pkg::flags_t qualify_reading(input reading_t r);
    paq_pkg::flags_t f;
    if (r.ph >= PHASES) return '0;
    f = flag_mem[r.ph];
    if (r.volt >= model_cfg.loss_threshold) begin
      loss_ok[r.ph] = r.stamp_ms;
      f.loss = 1'b0;
    end else if (held(r.stamp_ms, loss_ok[r.ph])) begin
      f.loss = 1'b1;
    end
    if (f.loss) begin
      f.vlow  = 1'b0;
      f.vhigh = 1'b0;
      f.ihigh = 1'b0;
      volt_ok[r.ph] = r.stamp_ms;
      curr_ok[r.ph] = r.stamp_ms;
    end else begin
      if (r.volt >= model_cfg.voltage_min && r.volt <= model_cfg.voltage_max) begin
        volt_ok[r.ph] = r.stamp_ms;
        f.vlow  = 1'b0;
        f.vhigh = 1'b0;
      end else if (held(r.stamp_ms, volt_ok[r.ph])) begin
        f.vlow  = (r.volt < model_cfg.voltage_min);
        f.vhigh = !f.vlow;
      end
      if (r.curr <= model_cfg.current_max) begin
        curr_ok[r.ph] = r.stamp_ms;
        f.ihigh = 1'b0;
      end else if (held(r.stamp_ms, curr_ok[r.ph])) begin
        f.ihigh = 1'b1;
      end
    end
    flag_mem[r.ph] = f;
    return f;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    $display("%0t ns  %s: expected %0h, got %0h", $time, what, want, got);
  endtask

  // input driver
  always @(negedge clk) begin : word_driver
    reading_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_hit) begin
      if (in_gap != 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (readings_todo.size() != 0) begin
        nxt = readings_todo.pop_front();
        phase_index <= nxt.ph;
        voltage_rms <= nxt.volt;
        current_rms <= nxt.curr;
        time_ms     <= nxt.stamp_ms;
        in_valid    <= 1'b1;
        in_gap = $urandom_range(0, gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall
  always @(negedge clk) begin : stall_driver
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_hit) stall_left = $urandom_range(0, stall_max);
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // accept, predict, check, watchdog
  always @(posedge clk) begin : monitor
    reading_t got;
    report_t  due;
    if (rst) begin
      in_hit  = 1'b0;
      out_hit = 1'b0;
    end else begin
      in_hit  = in_valid && !in_stall;
      out_hit = out_valid && !out_stall;
      if (in_hit) begin
        got.ph       = phase_index;
        got.volt     = voltage_rms;
        got.curr     = current_rms;
        got.stamp_ms = time_ms;
        due.ph       = phase_index;
        due.flags    = qualify_reading(got);
        flags_due.push_back(due);
        readings_taken++;
      end
      if (out_hit) begin
        if (flags_due.size() == 0) begin
          note_mismatch("result word with none due", '0,
                        32'({phase_out, phase_lost, current_high, voltage_high,
                             voltage_low}));
        end else begin
          due = flags_due.pop_front();
          if (phase_out !== due.ph)
            note_mismatch("phase_out", 32'(due.ph), 32'(phase_out));
          if (voltage_low !== due.flags.vlow)
            note_mismatch("voltage_low", 32'(due.flags.vlow), 32'(voltage_low));
          if (voltage_high !== due.flags.vhigh)
            note_mismatch("voltage_high", 32'(due.flags.vhigh), 32'(voltage_high));
          if (current_high !== due.flags.ihigh)
            note_mismatch("current_high", 32'(due.flags.ihigh), 32'(current_high));
          if (phase_lost !== due.flags.loss)
            note_mismatch("phase_lost", 32'(due.flags.loss), 32'(phase_lost));
        end
      end
      if (in_hit || out_hit ||
          (readings_taken == readings_fed && flags_due.size() == 0 && !psel)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= IDLE_LIMIT) begin
          $display("FAILED: results differ");
          $finish;
        end
      end
    end
  end

  task automatic write_reg(input paq_pkg::reg_idx_t idx, input logic [31:0] value);
    logic [31:0] width_mask;
    width_mask = (idx == paq_pkg::REG_MIN_DURATION) ? 32'hFFFF_FFFF : 32'h0000_FFFF;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= paq_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if ((prdata & width_mask) !== (value & width_mask))
      note_mismatch($sformatf("readback of %s", idx.name()), value & width_mask,
                    prdata & width_mask);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      paq_pkg::REG_VOLTAGE_MIN:    model_cfg.voltage_min    = value[15:0];
      paq_pkg::REG_VOLTAGE_MAX:    model_cfg.voltage_max    = value[15:0];
      paq_pkg::REG_CURRENT_MAX:    model_cfg.current_max    = value[15:0];
      paq_pkg::REG_LOSS_THRESHOLD: model_cfg.loss_threshold = value[15:0];
      paq_pkg::REG_MIN_DURATION:   model_cfg.min_duration   = value;
      default: ;
    endcase
  endtask

  task automatic queue_reading(input logic [1:0] ph, input logic [15:0] volt,
                               input logic [15:0] curr, input logic [31:0] stamp_ms);
    reading_t r;
    r.ph       = ph;
    r.volt     = volt;
    r.curr     = curr;
    r.stamp_ms = stamp_ms;
    readings_todo.push_back(r);
    readings_fed++;
  endtask

  task automatic drain();
    while (readings_taken != readings_fed || flags_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick(input int lo, input int hi);
    if (hi < lo) return 16'($urandom);
    return 16'($urandom_range(hi, lo));
  endfunction

  // mostly persistent per-phase faults so alarms get the chance to qualify
  task automatic queue_random_reading();
    logic [1:0]  ph;
    logic [15:0] volt;
    logic [15:0] curr;
    logic [2:0]  kind;
    int          vmin;
    int          vmax;
    int          imax;
    int          loss;
    vmin = int'(model_cfg.voltage_min);
    vmax = int'(model_cfg.voltage_max);
    imax = int'(model_cfg.current_max);
    loss = int'(model_cfg.loss_threshold);
    ph = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, PHASES - 1));
    kind = 3'd4;
    if (ph < PHASES) begin
      if ($urandom_range(0, 5) == 0) fault_kind[ph] = 3'($urandom_range(0, 4));
      if ($urandom_range(0, 5) == 0) over_current[ph] = !over_current[ph];
      kind = fault_kind[ph];
    end
    case (kind)
      3'd0:    volt = pick(vmin, vmax);
      3'd1:    volt = pick(loss, vmin - 1);
      3'd2:    volt = pick(vmax + 1, 65535);
      3'd3:    volt = pick(0, loss - 1);
      default: volt = 16'($urandom);
    endcase
    if ($urandom_range(0, 9) == 0)      curr = 16'($urandom);
    else if (ph < PHASES && over_current[ph]) curr = pick(imax + 1, 65535);
    else                                curr = pick(0, imax);
    if ($urandom_range(0, 63) == 0) clock_ms = $urandom;
    else                            clock_ms += $urandom_range(0, step_cap);
    queue_reading(ph, volt, curr, clock_ms);
  endtask

  task automatic run_setting(input logic [15:0] vmin, input logic [15:0] vmax,
                             input logic [15:0] imax, input logic [15:0] loss,
                             input logic [31:0] dur, input int unsigned count,
                             input int unsigned gaps, input int unsigned stalls);
    write_reg(paq_pkg::REG_VOLTAGE_MIN, 32'(vmin));
    write_reg(paq_pkg::REG_VOLTAGE_MAX, 32'(vmax));
    write_reg(paq_pkg::REG_CURRENT_MAX, 32'(imax));
    write_reg(paq_pkg::REG_LOSS_THRESHOLD, 32'(loss));
    write_reg(paq_pkg::REG_MIN_DURATION, dur);
    gap_max   = gaps;
    stall_max = stalls;
    step_cap  = (dur == 0) ? 1000 : dur / 4 + 1;
    repeat (count) queue_random_reading();
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // edge readings at reset settings
    gap_max   = 1;
    stall_max = 1;
    queue_reading(2'd3, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    queue_reading(2'd0, 16'd0, 16'd0, 32'd0);
    queue_reading(2'd1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    queue_reading(2'd2, 16'd1000, 16'd0, 32'd10000);
    queue_reading(2'd2, 16'd12000, 16'd0, 32'd10001);
    queue_reading(2'd0, 16'd10499, 16'd7000, 32'd20000);
    queue_reading(2'd0, 16'd10500, 16'd7001, 32'd20001);
    queue_reading(2'd0, 16'd13500, 16'd7001, 32'd25001);
    queue_reading(2'd0, 16'd13501, 16'd0, 32'd25002);
    queue_reading(2'd0, 16'd4999, 16'd0, 32'd30002);
    queue_reading(2'd1, 16'd12000, 16'd0, 32'hFFFF_F000);
    queue_reading(2'd1, 16'd14000, 16'd8000, 32'h0000_0500);
    queue_reading(2'd1, 16'd9000, 16'd8000, 32'h0000_0600);
    queue_reading(2'd2, 16'd0, 16'hFFFF, 32'h8000_0000);
    queue_reading(2'd3, 16'd0, 16'd0, 32'd0);
    queue_reading(2'd2, 16'd5000, 16'd0, 32'h8000_0001);
    queue_reading(2'd1, 16'hAAAA, 16'h5555, 32'h5555_5555);
    queue_reading(2'd2, 16'h5555, 16'hAAAA, 32'hAAAA_AAAA);
    drain();

    run_setting(16'd10500, 16'd13500, 16'd7000, 16'd5000, 32'd5000, 330, 0, 0);
    run_setting(16'd9000, 16'd15000, 16'd5000, 16'd3000, 32'd0, 330, 4, 4);
    run_setting(16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 330, 2, 0);
    run_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 330, 0, 4);
    run_setting(16'd20000, 16'd10000, 16'd30000, 16'd8000, 32'd2000, 330, 4, 2);
    run_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                $urandom_range(0, 20000), 330, 3, 3);

    if (mismatches == 0 && flags_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/paq_pkg.sv
hw/rtl/paq_regs.sv
hw/rtl/paq_state_mem.sv
hw/rtl/paq_update.sv
hw/rtl/phase_alarm_qualifier_top.sv
verif/tb_phase_alarm_qualifier_top.sv
